>>> hdl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types, character constants and the alphabet lookup of the base64
// text decoder
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PAD   = 8'h3d;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;

    localparam int unsigned BURST_MAX = 3;

    // alphabet lookup result
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } sextet_t;

    // up to three results caused by one character
    typedef struct packed {
        logic [1:0]                 count;     // 0 means no result
        logic                       has_data;  // 0 for a bare end marker
        logic                       eot;
        logic [BURST_MAX-1:0][7:0]  bytes;     // bytes[0] goes out first
    } burst_t;

    function automatic sextet_t map_char(input logic [7:0] ch);
        sextet_t    res;
        logic [7:0] diff;
        res  = '{ok: 1'b0, val: 6'd0};
        diff = 8'd0;
        case (ch) inside
            [8'h41:8'h5a]: begin
                diff = ch - 8'h41;
                res  = '{ok: 1'b1, val: diff[5:0]};
            end
            [8'h61:8'h7a]: begin
                diff = ch - 8'h61 + 8'd26;
                res  = '{ok: 1'b1, val: diff[5:0]};
            end
            [8'h30:8'h39]: begin
                diff = ch - 8'h30 + 8'd52;
                res  = '{ok: 1'b1, val: diff[5:0]};
            end
            CHAR_PLUS:  res = '{ok: 1'b1, val: 6'd62};
            CHAR_SLASH: res = '{ok: 1'b1, val: 6'd63};
            default:    res = '{ok: 1'b0, val: 6'd0};
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/b64d_quartet.sv
// ----------------------------------------------------------------------------
// b64d_quartet
// quartet state and per-character decode into a burst of results
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_quartet (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [7:0]        char_code,
    input  wire logic              end_of_text,
    output b64d_pkg::burst_t       burst
);

    logic [17:0] store_reg, store_next;
    logic [1:0]  held_reg,  held_next;
    logic [1:0]  pads_reg,  pads_next;

    b64d_pkg::sextet_t sx;
    logic [23:0]       full;

    assign sx   = b64d_pkg::map_char(char_code);
    assign full = {store_reg, sx.val};

    always_comb begin
        store_next     = store_reg;
        held_next      = held_reg;
        pads_next      = pads_reg;
        burst.count    = 2'd0;
        burst.has_data = 1'b1;
        burst.eot      = end_of_text;
        burst.bytes    = '0;

        if (char_code == b64d_pkg::CHAR_LF || char_code == b64d_pkg::CHAR_CR ||
            char_code == b64d_pkg::CHAR_SPACE) begin
            // skipped
        end else if (char_code == b64d_pkg::CHAR_PAD) begin
            if (pads_reg != 2'd3) begin
                pads_next = pads_reg + 2'd1;
            end
            if (held_reg == 2'd2) begin
                burst.count    = 2'd1;
                burst.bytes[0] = store_reg[11:4];
                store_next     = '0;
                held_next      = 2'd0;
            end else if (held_reg == 2'd3) begin
                burst.count    = 2'd2;
                burst.bytes[0] = store_reg[17:10];
                burst.bytes[1] = store_reg[9:2];
                store_next     = '0;
                held_next      = 2'd0;
            end
        end else if (!sx.ok) begin
            store_next = '0;
            held_next  = 2'd0;
        end else begin
            pads_next = 2'd0;
            if (held_reg == 2'd3) begin
                burst.count    = 2'd3;
                burst.bytes[0] = full[23:16];
                burst.bytes[1] = full[15:8];
                burst.bytes[2] = full[7:0];
                store_next     = '0;
                held_next      = 2'd0;
            end else begin
                store_next = {store_reg[11:0], sx.val};
                held_next  = held_reg + 2'd1;
            end
        end

        if (end_of_text) begin
            store_next = '0;
            held_next  = 2'd0;
            pads_next  = 2'd0;
            if (burst.count == 2'd0) begin
                // bare end marker
                burst.count    = 2'd1;
                burst.has_data = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg <= '0;
            held_reg  <= 2'd0;
            pads_reg  <= 2'd0;
        end else if (step) begin
            store_reg <= store_next;
            held_reg  <= held_next;
            pads_reg  <= pads_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/b64d_burst_out.sv
// ----------------------------------------------------------------------------
// b64d_burst_out
// result register that plays out one burst a request at a time
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_burst_out (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire b64d_pkg::burst_t  burst,
    output logic                   free,
    output logic [7:0]             m_data_byte,
    output logic                   m_byte_valid,
    output logic                   m_last_in_run,
    output logic                   m_text_done,
    output logic                   m_valid,
    input  wire logic              m_ready
);

    logic                                 valid_reg;
    logic [1:0]                           left_reg;
    logic                                 has_data_reg;
    logic                                 eot_reg;
    logic [b64d_pkg::BURST_MAX-1:0][7:0]  bytes_reg;
    logic                                 last;
    logic                                 take;

    assign last = (left_reg == 2'd1);
    assign take = valid_reg && m_ready;
    assign free = !valid_reg || (m_ready && last);

    assign m_valid       = valid_reg;
    assign m_data_byte   = bytes_reg[0];
    assign m_byte_valid  = has_data_reg;
    assign m_last_in_run = last;
    assign m_text_done   = last && eot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            left_reg  <= 2'd0;
        end else if (load) begin
            valid_reg <= 1'b1;
            left_reg  <= burst.count;
        end else if (take) begin
            valid_reg <= !last;
            left_reg  <= left_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            has_data_reg <= burst.has_data;
            eot_reg      <= burst.eot;
            bytes_reg    <= burst.bytes;
        end else if (take) begin
            bytes_reg <= {8'd0, bytes_reg[b64d_pkg::BURST_MAX-1:1]};
        end
    end

endmodule

`default_nettype wire

>>> hdl/base64_text_decoder.sv
// ----------------------------------------------------------------------------
// base64_text_decoder
// streaming base64 decoder, one text character per request in
// ----------------------------------------------------------------------------
// One character is taken per cycle while the input is not stalled. A
// character passes an input register, is decoded against the held quartet
// in a single pass, and its results (up to three bytes, or a bare end
// marker on a flagged character that releases nothing) are loaded into a
// result register that plays them out one request per cycle while
// m_ready is high. Whitespace, invalid characters and early pads give
// nothing. The input rate is one character per cycle as long as each burst
// leaves the result register before the next burst is ready; a full
// quartet's three bytes are played out one at a time, so the sustained
// rate is set by the result port.
`default_nettype none

module base64_text_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // character input
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_end_of_text,
    input  wire logic        s_valid,
    output logic             s_ready,
    // decoded byte output
    output logic [7:0]       m_data_byte,
    output logic             m_byte_valid,
    output logic             m_last_in_run,
    output logic             m_text_done,
    output logic             m_valid,
    input  wire logic        m_ready
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_eot_reg;

    b64d_pkg::burst_t burst;
    logic             out_free;
    logic             advance;

    // the held character moves on when it gives nothing or the result
    // register can take its burst this cycle
    assign advance = in_valid_reg && (burst.count == 2'd0 || out_free);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_code;
            in_eot_reg  <= s_end_of_text;
        end
    end

    // quartet gathering and decode
    b64d_quartet u_quartet (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .char_code   (in_char_reg),
        .end_of_text (in_eot_reg),
        .burst       (burst)
    );

    // result register and play-out
    b64d_burst_out u_burst_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance && burst.count != 2'd0),
        .burst         (burst),
        .free          (out_free),
        .m_data_byte   (m_data_byte),
        .m_byte_valid  (m_byte_valid),
        .m_last_in_run (m_last_in_run),
        .m_text_done   (m_text_done),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

endmodule

`default_nettype wire

>>> dv/tb_base64_text_decoder.sv
// ----------------------------------------------------------------------------
// tb_base64_text_decoder
// self-checking bench for the streaming base64 text decoder: a short table
// of directed characters, then random encoded texts with blanks, pads,
// invalid bytes and cut-off quartets, checked result by result against a
// behavioral decoder running beside the block
// ----------------------------------------------------------------------------
module tb_base64_text_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    // one result request as it should leave the block
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_in_run;
        logic       text_done;
    } byte_beat_t;

    // one directed character; pinned rows carry their results typed in
    typedef struct packed {
        logic [7:0]  char_code;
        logic        end_of_text;
        logic        pinned;
        logic [1:0]  pin_n;
        logic [23:0] pin_bytes;
    } script_row_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic [7:0]  s_char_code   = 8'h00;
    logic        s_end_of_text = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  m_data_byte;
    logic        m_byte_valid;
    logic        m_last_in_run;
    logic        m_text_done;
    logic        m_valid;
    logic        m_ready       = 1'b0;

    // decoder state of the behavioral copy
    logic [17:0] quartet_bits = '0;
    logic [1:0]  quartet_cnt  = '0;
    logic [1:0]  pad_run      = '0;

    byte_beat_t  beat_buf [3];
    byte_beat_t  beats_due [$];
    script_row_t script [$];

    int          bad_count     = 0;
    int          decoded_chars = 0;
    int          idle_phase    = 0;
    int          src_idle_pct  = 0;
    int          snk_idle_pct  = 0;
    logic        sink_hold     = 1'b0;

    base64_text_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_char_code   (s_char_code),
        .s_end_of_text (s_end_of_text),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .m_data_byte   (m_data_byte),
        .m_byte_valid  (m_byte_valid),
        .m_last_in_run (m_last_in_run),
        .m_text_done   (m_text_done),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // behavioral decoder
    // ------------------------------------------------------------------

    function automatic byte_beat_t data_beat(input logic [7:0] b);
        return '{data_byte: b, byte_valid: 1'b1, last_in_run: 1'b0, text_done: 1'b0};
    endfunction

    // decodes one accepted character, leaves its results in beat_buf and
    // returns how many there are
    function automatic int decode_char(input logic [7:0] ch, input logic eot);
        logic [5:0]  sx;
        logic        in_alphabet;
        logic [23:0] full;
        int          n;
        n           = 0;
        sx          = '0;
        in_alphabet = 1'b1;
        if (ch >= "A" && ch <= "Z") begin
            sx = 6'(ch - "A");
        end else if (ch >= "a" && ch <= "z") begin
            sx = 6'(ch - "a" + 8'd26);
        end else if (ch >= "0" && ch <= "9") begin
            sx = 6'(ch - "0" + 8'd52);
        end else if (ch == b64d_pkg::CHAR_PLUS) begin
            sx = 6'd62;
        end else if (ch == b64d_pkg::CHAR_SLASH) begin
            sx = 6'd63;
        end else begin
            in_alphabet = 1'b0;
        end

        if (ch == b64d_pkg::CHAR_LF || ch == b64d_pkg::CHAR_CR ||
            ch == b64d_pkg::CHAR_SPACE) begin
            // blanks pass through untouched
        end else if (ch == b64d_pkg::CHAR_PAD) begin
            if (pad_run != 2'd3) pad_run = pad_run + 2'd1;
            // a pad closes the quartet only once two or three sextets sit in it;
            // leftover low bits are simply cut off
            if (quartet_cnt == 2'd2) begin
                beat_buf[n++] = data_beat(quartet_bits[11:4]);
                quartet_bits  = '0;
                quartet_cnt   = '0;
            end else if (quartet_cnt == 2'd3) begin
                beat_buf[n++] = data_beat(quartet_bits[17:10]);
                beat_buf[n++] = data_beat(quartet_bits[9:2]);
                quartet_bits  = '0;
                quartet_cnt   = '0;
            end
        end else if (!in_alphabet) begin
            // invalid byte throws the partial quartet away
            quartet_bits = '0;
            quartet_cnt  = '0;
        end else begin
            pad_run = '0;
            if (quartet_cnt == 2'd3) begin
                full          = {quartet_bits, sx};
                beat_buf[n++] = data_beat(full[23:16]);
                beat_buf[n++] = data_beat(full[15:8]);
                beat_buf[n++] = data_beat(full[7:0]);
                quartet_bits  = '0;
                quartet_cnt   = '0;
            end else begin
                quartet_bits = {quartet_bits[11:0], sx};
                quartet_cnt  = quartet_cnt + 2'd1;
            end
        end

        if (n > 0) begin
            beat_buf[n-1].last_in_run = 1'b1;
            beat_buf[n-1].text_done   = eot;
        end
        if (eot) begin
            // end of text drops whatever quartet is left and marks the end
            if (n == 0) begin
                beat_buf[0] = '{data_byte: 8'h00, byte_valid: 1'b0,
                                last_in_run: 1'b1, text_done: 1'b1};
                n = 1;
            end
            quartet_bits = '0;
            quartet_cnt  = '0;
            pad_run      = '0;
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offers one character, waits for its request to be taken and books
    // the results it should cause
    task automatic push_char(input logic [7:0] ch, input logic eot,
                             input logic pinned = 1'b0, input int pin_n = 0,
                             input logic [23:0] pin_bytes = '0);
        byte_beat_t beat;
        int         n;
        int         k;
        // random gap before the request, one idle decision per cycle
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_code   <= ch;
        s_end_of_text <= eot;
        do @(posedge aclk); while (!s_ready);

        // accepted at this edge; the decoder copy always runs to keep its state
        n = decode_char(ch, eot);
        if (pinned) begin
            if (pin_n == 0) begin
                beats_due.push_back('{data_byte: 8'h00, byte_valid: 1'b0,
                                      last_in_run: 1'b1, text_done: 1'b1});
            end else begin
                for (k = 0; k < pin_n; k++) begin
                    beat.data_byte   = pin_bytes[23 - 8*k -: 8];
                    beat.byte_valid  = 1'b1;
                    beat.last_in_run = (k == pin_n - 1);
                    beat.text_done   = eot && (k == pin_n - 1);
                    beats_due.push_back(beat);
                end
            end
        end else begin
            for (k = 0; k < n; k++) beats_due.push_back(beat_buf[k]);
        end
        decoded_chars++;
    endtask

    task automatic add_row(input logic [7:0] ch, input logic eot = 1'b0,
                           input logic pinned = 1'b0, input int pin_n = 0,
                           input logic [23:0] pin_bytes = '0);
        script.push_back('{char_code: ch, end_of_text: eot, pinned: pinned,
                           pin_n: 2'(pin_n), pin_bytes: pin_bytes});
    endtask

    // stop offering and wait until every booked result has come out
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_sym();
        logic [5:0] v;
        v = 6'($urandom_range(0, 63));
        if (v < 26) return "A" + 8'(v);
        if (v < 52) return "a" + 8'(v) - 8'd26;
        if (v < 62) return "0" + 8'(v) - 8'd52;
        if (v == 62) return b64d_pkg::CHAR_PLUS;
        return b64d_pkg::CHAR_SLASH;
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 2))
            0:       return b64d_pkg::CHAR_LF;
            1:       return b64d_pkg::CHAR_CR;
            default: return b64d_pkg::CHAR_SPACE;
        endcase
    endfunction

    // one random piece of text: mostly well-formed quartets with a random
    // ending, sometimes plain byte noise
    task automatic send_random_text();
        logic [7:0] text [$];
        logic       flag;
        if ($urandom_range(0, 99) < 12) begin
            // noise, any byte value, flagged half the time
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
            flag = 1'($urandom_range(0, 1));
        end else begin
            repeat ($urandom_range(0, 4)) repeat (4) text.push_back(random_sym());
            case ($urandom_range(0, 9))
                0, 1: begin
                    // ends on a full quartet
                end
                2: text.push_back(random_blank());
                3, 4: begin
                    // one byte in the last quartet
                    repeat (2) text.push_back(random_sym());
                    text.push_back(b64d_pkg::CHAR_PAD);
                    text.push_back(b64d_pkg::CHAR_PAD);
                end
                5, 6: begin
                    // two bytes in the last quartet
                    repeat (3) text.push_back(random_sym());
                    text.push_back(b64d_pkg::CHAR_PAD);
                end
                7: begin
                    // a bad byte in the middle of a quartet
                    repeat ($urandom_range(1, 3)) text.push_back(random_sym());
                    text.push_back(8'($urandom_range(0, 255)));
                    repeat ($urandom_range(0, 3)) text.push_back(random_sym());
                end
                8: begin
                    // cut off inside a quartet
                    repeat ($urandom_range(1, 3)) text.push_back(random_sym());
                end
                default: begin
                    // stray pad ahead of a padded quartet
                    text.push_back(b64d_pkg::CHAR_PAD);
                    repeat (2) text.push_back(random_sym());
                    text.push_back(b64d_pkg::CHAR_PAD);
                end
            endcase
            if (text.size() == 0) text.push_back(random_blank());
            // an unflagged text runs on into the next one
            flag = ($urandom_range(0, 9) != 0);
        end
        foreach (text[k]) begin
            if ($urandom_range(0, 7) == 0) push_char(random_blank(), 1'b0);
            push_char(text[k], flag && (k == text.size() - 1));
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        int p;
        int start_count;

        // directed table
        add_row(8'h00, 1'b1, 1'b1, 0);                // lowest byte, flagged: end marker only
        add_row("T");
        add_row("W");
        add_row(b64d_pkg::CHAR_CR);                   // blank inside a quartet
        add_row("F");
        add_row("u", 1'b0, 1'b1, 3, 24'h4d616e);      // full quartet, three bytes
        add_row(b64d_pkg::CHAR_SLASH);
        add_row(b64d_pkg::CHAR_SLASH);
        add_row(b64d_pkg::CHAR_SLASH);
        // all ones, last byte ends text
        add_row(b64d_pkg::CHAR_SLASH, 1'b1, 1'b1, 3, 24'hffffff);
        add_row(b64d_pkg::CHAR_PLUS);
        add_row("z");
        add_row("9");                                 // nonzero pad bits left over
        add_row(b64d_pkg::CHAR_PAD);                  // pad after three sextets
        add_row("0");
        add_row(b64d_pkg::CHAR_LF);
        add_row("a");
        add_row(b64d_pkg::CHAR_SPACE);
        add_row(b64d_pkg::CHAR_PAD);                  // pad after two sextets
        add_row(b64d_pkg::CHAR_PAD);                  // second pad of a double pad
        add_row("Q");
        add_row("m");
        add_row(8'hff);                               // highest byte, invalid, drops quartet
        add_row("Z");
        add_row("m");
        add_row("9", 1'b1, 1'b1, 0);                  // partial quartet at end of text

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        idle_phase   = 0;
        src_idle_pct = 37;
        snk_idle_pct = 78;
        foreach (script[p])
            push_char(script[p].char_code, script[p].end_of_text, script[p].pinned,
                      int'(script[p].pin_n), script[p].pin_bytes);
        // sender pauses until every booked result is out
        wait_for_drain();

        // random texts in three idling phases: sparse receiver, then sparse
        // sender, then full rate on both sides
        for (p = 0; p < 3; p++) begin
            idle_phase   = p;
            src_idle_pct = (p == 0) ? 37 : (p == 1) ? 78 : 0;
            snk_idle_pct = (p == 0) ? 78 : (p == 1) ? 37 : 0;
            start_count  = decoded_chars;
            while (decoded_chars - start_count < 115) send_random_text();
            wait_for_drain();
        end

        // let any stray result show up
        repeat (8) @(posedge aclk);
        if (bad_count == 0) begin
            $display("tb_base64_text_decoder: done, clean");
        end else begin
            $display("tb_base64_text_decoder: done, errors");
        end
        $finish;
    end

    // long receiver hold-off in the full-rate phase so the block backs up
    // and stalls its input while the sender keeps offering
    initial begin : sink_hold_off
        wait (idle_phase == 2);
        repeat (20) @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (120) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            bad_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_sink
        byte_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (beats_due.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got data_byte %0h",
                         $time, m_data_byte);
                bad_count++;
            end else begin
                want = beats_due.pop_front();
                check_field("data_byte", want.data_byte, m_data_byte);
                check_field("byte_valid", 8'(want.byte_valid), 8'(m_byte_valid));
                check_field("last_in_run", 8'(want.last_in_run), 8'(m_last_in_run));
                check_field("text_done", 8'(want.text_done), 8'(m_text_done));
            end
        end
        // random backpressure, with ready forced low during the hold-off stretch
        m_ready <= !sink_hold && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // watchdog
    initial begin : watchdog
        #2_000_000;
        $display("tb_base64_text_decoder: done, errors");
        $finish;
    end

endmodule
